/* rtl/vff_pkg.sv */
package vff_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned GainW   = 31;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned RegIdxW = 3;

  // gain reset values in whole units, scaled by the fraction bits at the top
  localparam int unsigned AxialInit    = 10;
  localparam int unsigned VerticalInit = 40;

  typedef enum logic [RegIdxW-1:0] {
    REG_EYE_X         = 3'd0,
    REG_EYE_Y         = 3'd1,
    REG_EYE_Z         = 3'd2,
    REG_AXIAL_GAIN    = 3'd3,
    REG_VERTICAL_GAIN = 3'd4
  } vff_reg_e;

endpackage

/* rtl/vff_if.sv */
interface vff_in_if import vff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [CoordW-1:0] pos_z;
  logic [GainW-1:0]  body_mass;

  modport source (output valid, pos_x, pos_y, pos_z, body_mass, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, body_mass, output ready);
endinterface

interface vff_out_if import vff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] force_x;
  logic [CoordW-1:0] force_y;
  logic [CoordW-1:0] force_z;

  modport source (output valid, force_x, force_y, force_z, input ready);
  modport sink   (input valid, force_x, force_y, force_z, output ready);
endinterface

interface vff_cfg_if import vff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [CoordW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/vortex_force_field_core.sv */
// Vortex force on one body per word: position and mass in, force out, all fixed
// point with FRAC_BITS fraction bits (signed, but mass unsigned), results saturated
// to 32 bits. A word is taken every cycle while the output side keeps up; the force
// comes from three pipelined dividers and one pipelined square root that each
// resolve one result bit per stage.
// The whole pipeline holds as one while a finished force waits at the output.
// Registers: eye_x, eye_y, eye_z, axial_gain, vertical_gain at indexes 0 to 4;
// write them only while no body is in flight. Other indexes are ignored.
module vortex_force_field_core import vff_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  vff_in_if.sink    in_i,
  vff_out_if.source out_o,
  vff_cfg_if.sink   cfg_i
);

  localparam int unsigned Fb   = FRAC_BITS;
  localparam int unsigned SW   = SqW + 1 - Fb;
  localparam int unsigned NaW  = GainW + Fb;
  localparam int unsigned NbW  = CoordW + Fb;
  localparam int unsigned GxW  = CoordW + 2;
  localparam logic [CoordW-1:0] One32 = CoordW'(1) << Fb;
  localparam logic [SW-1:0]     OneS  = SW'(1) << Fb;
  localparam logic [RootW:0]    OneD  = (RootW + 1)'(1) << Fb;

  typedef struct packed {
    logic             sx;
    logic             sz;
    logic [31:0]      ax;
    logic [31:0]      az;
    logic [SW-1:0]    s;
    logic [GainW-1:0] mass;
  } s1_t;

  typedef struct packed {
    logic [31:0]      fx;
    logic [31:0]      fz;
    logic [GainW-1:0] mass;
  } s2_t;

  typedef struct packed {
    logic [31:0]      fx;
    logic [31:0]      fz;
    logic [30:0]      fy;
    logic [GainW-1:0] mass;
  } s3_t;

  function automatic logic [31:0] sat_mag(logic neg, logic [63:0] m);
    logic [31:0] r;
    if (neg) begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  // configuration
  logic [CoordW-1:0] eye_x_q, eye_y_q, eye_z_q;
  logic [GainW-1:0]  axial_q, vert_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_x_q <= '0;
      eye_y_q <= '0;
      eye_z_q <= '0;
      axial_q <= GainW'(AxialInit) << Fb;
      vert_q  <= GainW'(VerticalInit) << Fb;
    end else if (cfg_i.valid) begin
      case (vff_reg_e'(cfg_i.index))
        REG_EYE_X:         eye_x_q <= cfg_i.data;
        REG_EYE_Y:         eye_y_q <= cfg_i.data;
        REG_EYE_Z:         eye_z_q <= cfg_i.data;
        REG_AXIAL_GAIN:    axial_q <= cfg_i.data[GainW-1:0];
        REG_VERTICAL_GAIN: vert_q  <= cfg_i.data[GainW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic vo_q;
  assign en         = !vo_q || out_o.ready;
  assign in_i.ready = en;

  // stage a: offsets from body to eye
  logic                    va_q;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic [GainW-1:0]        mass_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= $signed({eye_x_q[31], eye_x_q}) - $signed({in_i.pos_x[31], in_i.pos_x});
      dy_q <= $signed({eye_y_q[31], eye_y_q}) - $signed({in_i.pos_y[31], in_i.pos_y});
      dz_q <= $signed({eye_z_q[31], eye_z_q}) - $signed({in_i.pos_z[31], in_i.pos_z});
      mass_a_q <= in_i.body_mass;
    end
  end

  // stage b: magnitudes, squares, vertical clamp
  logic             vb_q;
  logic [63:0]      sqx_q, sqz_q;
  logic [31:0]      ax_b_q, az_b_q, ry_b_q;
  logic             sx_b_q, sz_b_q;
  logic [GainW-1:0] mass_b_q;
  logic [DiffW-1:0] ndx, ndy, ndz;
  logic [31:0]      ax, ay, az;

  assign ndx = -dx_q;
  assign ndy = -dy_q;
  assign ndz = -dz_q;
  assign ax  = dx_q[DiffW-1] ? ndx[31:0] : dx_q[31:0];
  assign ay  = dy_q[DiffW-1] ? ndy[31:0] : dy_q[31:0];
  assign az  = dz_q[DiffW-1] ? ndz[31:0] : dz_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= 64'(ax) * 64'(ax);
      sqz_q    <= 64'(az) * 64'(az);
      ax_b_q   <= ax;
      az_b_q   <= az;
      sx_b_q   <= dx_q[DiffW-1];
      sz_b_q   <= dz_q[DiffW-1];
      ry_b_q   <= (ay < One32) ? One32 : ay;
      mass_b_q <= mass_a_q;
    end
  end

  // stage c: clamped horizontal squared distance
  logic             vc_q;
  logic [31:0]      ry_c_q;
  s1_t              s1_c_q;
  logic [SW-1:0]    s_sum;

  assign s_sum = SW'(sqx_q >> Fb) + SW'(sqz_q >> Fb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_c_q      <= ry_b_q;
      s1_c_q.sx   <= sx_b_q;
      s1_c_q.sz   <= sz_b_q;
      s1_c_q.ax   <= ax_b_q;
      s1_c_q.az   <= az_b_q;
      s1_c_q.s    <= (s_sum < OneS) ? OneS : s_sum;
      s1_c_q.mass <= mass_b_q;
    end
  end

  s1_t s1_out;

  // gain ratios over the vertical offset
  logic                 v1_o;
  logic [1:0][NaW-1:0]  g_num, g_quo;
  logic [$bits(s1_t)-1:0] s1_vec;

  assign g_num[0] = {axial_q, Fb'(0)};
  assign g_num[1] = {vert_q, Fb'(0)};

  vff_div_pipe #(
    .NumW (NaW),
    .DenW (32),
    .Lanes(2),
    .SideW($bits(s1_t))
  ) u_div_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vc_q),
    .num_i  (g_num),
    .den_i  (ry_c_q),
    .side_i (s1_c_q),
    .valid_o(v1_o),
    .quo_o  (g_quo),
    .side_o (s1_vec)
  );
  assign s1_out = s1_vec;

  // stage m1/m2: horizontal force, saturated
  logic             vm1_q, vm2_q;
  logic [62:0]      px_q, pz_q;
  logic [30:0]      gv_m1_q, gv_m2_q;
  s1_t              s1_m1_q;
  logic [SW-1:0]    s_m2_q;
  s2_t              s2_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
    end else if (en) begin
      vm1_q <= v1_o;
      vm2_q <= vm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q         <= 63'(s1_out.ax) * 63'(g_quo[0][30:0]);
      pz_q         <= 63'(s1_out.az) * 63'(g_quo[0][30:0]);
      gv_m1_q      <= g_quo[1][30:0];
      s1_m1_q      <= s1_out;
      s2_m2_q.fx   <= sat_mag(s1_m1_q.sx, 64'(px_q >> Fb));
      s2_m2_q.fz   <= sat_mag(s1_m1_q.sz, 64'(pz_q >> Fb));
      s2_m2_q.mass <= s1_m1_q.mass;
      gv_m2_q      <= gv_m1_q;
      s_m2_q       <= s1_m1_q.s;
    end
  end

  // vertical force
  logic                   vy_o;
  logic [0:0][NaW-1:0]    y_num, y_quo;
  logic [$bits(s2_t)-1:0] s2_vec;
  s2_t                    s2_out;

  assign y_num[0] = {gv_m2_q, Fb'(0)};

  vff_div_pipe #(
    .NumW (NaW),
    .DenW (SW),
    .Lanes(1),
    .SideW($bits(s2_t))
  ) u_div_vert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vm2_q),
    .num_i  (y_num),
    .den_i  (s_m2_q),
    .side_i (s2_m2_q),
    .valid_o(vy_o),
    .quo_o  (y_quo),
    .side_o (s2_vec)
  );
  assign s2_out = s2_vec;

  // stage q1/q2: squared length
  logic        vq1_q, vq2_q;
  logic [63:0] qx_q, qy_q, qz_q, len2_q;
  s3_t         s3_q1_q, s3_q2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq1_q <= 1'b0;
      vq2_q <= 1'b0;
    end else if (en) begin
      vq1_q <= vy_o;
      vq2_q <= vq1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q         <= 64'(mag32(s2_out.fx)) * 64'(mag32(s2_out.fx));
      qz_q         <= 64'(mag32(s2_out.fz)) * 64'(mag32(s2_out.fz));
      qy_q         <= 64'(y_quo[0][30:0]) * 64'(y_quo[0][30:0]);
      s3_q1_q.fx   <= s2_out.fx;
      s3_q1_q.fz   <= s2_out.fz;
      s3_q1_q.fy   <= y_quo[0][30:0];
      s3_q1_q.mass <= s2_out.mass;
      len2_q       <= qx_q + qy_q + qz_q;
      s3_q2_q      <= s3_q1_q;
    end
  end

  logic                   vr_o;
  logic [RootW-1:0]       root;
  logic [$bits(s3_t)-1:0] s3_r_vec;
  s3_t                    s3_r;

  vff_sqrt_pipe #(
    .SideW($bits(s3_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vq2_q),
    .x_i    (len2_q),
    .side_i (s3_q2_q),
    .valid_o(vr_o),
    .root_o (root),
    .side_o (s3_r_vec)
  );
  assign s3_r = s3_r_vec;

  // swirl term over |f| + 1
  logic                   vw_o;
  logic [RootW:0]         den_w;
  logic [1:0][NbW-1:0]    w_num, w_quo;
  logic [$bits(s3_t)-1:0] s3_w_vec;
  s3_t                    s3_w;

  assign den_w    = {1'b0, root} + OneD;
  assign w_num[0] = {mag32(s3_r.fz), Fb'(0)};
  assign w_num[1] = {mag32(s3_r.fx), Fb'(0)};

  vff_div_pipe #(
    .NumW (NbW),
    .DenW (RootW + 1),
    .Lanes(2),
    .SideW($bits(s3_t))
  ) u_div_swirl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vr_o),
    .num_i  (w_num),
    .den_i  (den_w),
    .side_i (s3_r),
    .valid_o(vw_o),
    .quo_o  (w_quo),
    .side_o (s3_w_vec)
  );
  assign s3_w = s3_w_vec;

  // stage g: swirled components
  logic             vg_q;
  logic [GxW-1:0]   gx_q, gz_q;
  logic [30:0]      fy_g_q;
  logic [GainW-1:0] mass_g_q;
  logic             fz_pos;
  logic [GxW-1:0]   tx, tz;

  assign fz_pos = !s3_w.fz[31] && (s3_w.fz != '0);
  assign tx = fz_pos ? GxW'(-{2'b00, w_quo[0][31:0]}) : {2'b00, w_quo[0][31:0]};
  assign tz = s3_w.fx[31] ? GxW'(-{2'b00, w_quo[1][31:0]}) : {2'b00, w_quo[1][31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= vw_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q     <= {{2{s3_w.fx[31]}}, s3_w.fx} + tx;
      gz_q     <= {{2{s3_w.fz[31]}}, s3_w.fz} + tz;
      fy_g_q   <= s3_w.fy;
      mass_g_q <= s3_w.mass;
    end
  end

  // stage p: mass scaling, then saturate into the output register
  logic           vp_q;
  logic [63:0]    pgx_q, pgz_q, pfy_q;
  logic           sgx_q, sgz_q;
  logic [GxW-1:0] ngx, ngz;
  logic [32:0]    mgx, mgz;
  logic [31:0]    fo_x_q, fo_y_q, fo_z_q;

  assign ngx = -gx_q;
  assign ngz = -gz_q;
  assign mgx = gx_q[GxW-1] ? ngx[32:0] : gx_q[32:0];
  assign mgz = gz_q[GxW-1] ? ngz[32:0] : gz_q[32:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vp_q <= vg_q;
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pgx_q  <= 64'(mgx) * 64'(mass_g_q);
      pgz_q  <= 64'(mgz) * 64'(mass_g_q);
      pfy_q  <= 64'(fy_g_q) * 64'(mass_g_q);
      sgx_q  <= gx_q[GxW-1];
      sgz_q  <= gz_q[GxW-1];
      fo_x_q <= sat_mag(sgx_q, pgx_q >> Fb);
      fo_y_q <= sat_mag(1'b0, pfy_q >> Fb);
      fo_z_q <= sat_mag(sgz_q, pgz_q >> Fb);
    end
  end

  assign out_o.valid   = vo_q;
  assign out_o.force_x = fo_x_q;
  assign out_o.force_y = fo_y_q;
  assign out_o.force_z = fo_z_q;

  // vertical pull and mass are never negative
  a_force_y_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !fo_y_q[31])
    else $error("negative vertical force");

  a_dist_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (s1_c_q.s >= OneS) && (ry_c_q >= One32))
    else $error("divisor below one");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vp_q && !en) |=> vp_q && $stable(pgx_q) && $stable(pfy_q))
    else $error("pipeline moved during stall");

endmodule

/* rtl/vff_div_pipe.sv */
module vff_div_pipe #(
  parameter int unsigned NumW  = 47,
  parameter int unsigned DenW  = 32,
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [Lanes-1:0][NumW-1:0]       num_i,
  input  logic [DenW-1:0]                  den_i,
  input  logic [SideW-1:0]                 side_i,
  output logic                             valid_o,
  output logic [Lanes-1:0][NumW-1:0]       quo_o,
  output logic [SideW-1:0]                 side_o
);

  logic [NumW-1:0]                   valid_q;
  logic [Lanes-1:0][DenW-1:0]        rem_q  [NumW];
  logic [Lanes-1:0][NumW-1:0]        num_q  [NumW];
  logic [DenW-1:0]                   den_q  [NumW];
  logic [SideW-1:0]                  side_q [NumW];

  // one quotient bit per stage; numerator bits shift out, quotient bits shift in
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic                       vin;
    logic [Lanes-1:0][DenW-1:0] rin;
    logic [Lanes-1:0][NumW-1:0] nin;
    logic [DenW-1:0]            din;
    logic [SideW-1:0]           sin;
    logic [Lanes-1:0][DenW-1:0] rem_d;
    logic [Lanes-1:0][NumW-1:0] num_d;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign rin = rem_q[s-1];
      assign nin = num_q[s-1];
      assign din = den_q[s-1];
      assign sin = side_q[s-1];
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [DenW:0] trial;
      logic [DenW:0] diff;
      logic          ge;
      assign trial = {rin[l], nin[l][NumW-1]};
      assign diff  = trial - {1'b0, din};
      assign ge    = trial >= {1'b0, din};
      assign rem_d[l] = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      assign num_d[l] = {nin[l][NumW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        num_q[s]  <= num_d;
        den_q[s]  <= din;
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = valid_q[NumW-1];
  assign quo_o   = num_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

/* rtl/vff_sqrt_pipe.sv */
module vff_sqrt_pipe import vff_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SqW-1:0]    x_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [RootW-1:0]  root_o,
  output logic [SideW-1:0]  side_o
);

  localparam int unsigned RemW = RootW + 2;

  logic [RootW-1:0] valid_q;
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [SqW-1:0]   x_q    [RootW];
  logic [SideW-1:0] side_q [RootW];

  // two radicand bits per stage, one root bit out
  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic             vin;
    logic [RemW-1:0]  rin;
    logic [RootW-1:0] oin;
    logic [SqW-1:0]   xin;
    logic [SideW-1:0] sin;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  test;
    logic [RemW+1:0]  diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign oin = '0;
      assign xin = x_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign rin = rem_q[s-1];
      assign oin = root_q[s-1];
      assign xin = x_q[s-1];
      assign sin = side_q[s-1];
    end

    assign trial = {rin, xin[SqW-1 -: 2]};
    assign test  = {2'b00, oin, 2'b01};
    assign diff  = trial - test;
    assign ge    = trial >= test;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
        root_q[s] <= {oin[RootW-2:0], ge};
        x_q[s]    <= {xin[SqW-3:0], 2'b00};
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule
